### sv/bcd_pkg.sv
// Shared types and constants for the bounded circular deque.
`default_nettype none
package bcd_pkg;

	// Width of a stored word.
	localparam int WORD_W = 32;

	// Default number of cells in the chain.
	localparam int DEPTH_DEFAULT = 16;

	// Capacity register width and reset value.
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Configuration bus geometry and register addresses.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

	// Word returned for the front and rear when the deque is empty.
	localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

	// Operation codes.
	typedef enum logic [1:0] {
		MODE_INS_FRONT = 2'd0,
		MODE_INS_REAR  = 2'd1,
		MODE_DEL_FRONT = 2'd2,
		MODE_DEL_REAR  = 2'd3
	} mode_t;

	// Control broadcast to every cell.
	typedef struct packed {
		logic              go;
		mode_t             mode;
		logic [WORD_W-1:0] data;
	} cell_ctl_t;

endpackage
`default_nettype wire

### sv/bcd_cell.sv
// One storage cell of the deque chain.
`default_nettype none
module bcd_cell
	import bcd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [WORD_W-1:0] left_value,
	input  wire logic              left_valid,
	input  wire logic [WORD_W-1:0] right_value,
	input  wire logic              right_valid,
	input  wire logic [WORD_W-1:0] rear_in,
	output logic      [WORD_W-1:0] cell_value,
	output logic                   cell_valid,
	output logic      [WORD_W-1:0] rear_out
);

	logic [WORD_W-1:0] value_q;
	logic              valid_q;
	logic [WORD_W-1:0] value_d;
	logic              valid_d;
	logic              is_rear;

	// This cell holds the rear entry when it is the last occupied cell.
	assign is_rear = valid_q && !right_valid;

	// Next contents: shift toward the rear, shift toward the front, or act at the rear.
	always_comb begin
		value_d = value_q;
		valid_d = valid_q;
		if (ctl.go) begin
			unique case (ctl.mode)
				MODE_INS_FRONT: begin
					value_d = left_value;
					valid_d = left_valid;
				end
				MODE_INS_REAR: begin
					if (!valid_q && left_valid) begin
						value_d = ctl.data;
						valid_d = 1'b1;
					end
				end
				MODE_DEL_FRONT: begin
					value_d = right_value;
					valid_d = right_valid;
				end
				MODE_DEL_REAR: begin
					if (is_rear) begin
						valid_d = 1'b0;
					end
				end
				default: begin
					value_d = value_q;
					valid_d = valid_q;
				end
			endcase
		end
	end

	// Occupancy flag is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Stored word needs no reset.
	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	// Rear word is collected along the chain toward the front.
	assign rear_out   = rear_in | (is_rear ? value_q : '0);
	assign cell_value = value_q;
	assign cell_valid = valid_q;

endmodule
`default_nettype wire

### sv/bounded_circular_deque.sv
// Top level of the bounded double-ended queue built from a chain of cells.
// The deque keeps its entries packed in a row of DEPTH cells, the front in the first cell,
// and every successful operation moves all cells at once: an insert at the front or a
// delete from the front shifts the whole row by one place, while an insert or delete at
// the rear acts on the cell at the boundary of the occupied part. The cells and the entry
// count are updated at the edge that accepts the transaction, and the result (success
// flag, front and rear words, empty and full flags) is captured from the updated row into
// an output register once that register is free. Input is taken again in the cycle after
// that capture, so a new operation is accepted while a finished result still waits to be
// taken; while the output register is held by a stalled result, input waits. The rear
// word is gathered through the cell chain, which sets the critical path for large DEPTH.
// Cell occupancy flags are cleared by reset, so no clearing pass is needed. The
// capacity register sits at address 0 of the APB port; values above DEPTH act as DEPTH,
// and a capacity of zero refuses every insert.
`default_nettype none
module bounded_circular_deque
	import bcd_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Operation channel.
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic        [1:0]         mode,
	input  wire logic signed [WORD_W-1:0]  value,
	// Result channel.
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           ok,
	output logic signed      [WORD_W-1:0]  front_value,
	output logic signed      [WORD_W-1:0]  rear_value,
	output logic                           is_empty,
	output logic                           is_full,
	// Configuration port.
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic        [PADDR_W-1:0] paddr,
	input  wire logic        [PDATA_W-1:0] pwdata,
	output logic             [PDATA_W-1:0] prdata,
	output logic                           pready
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0]  capacity_q;
	logic [CNT_W-1:0]  count_q;
	logic              busy_q;
	logic              ok_q;
	logic              out_valid_q;
	logic              out_ok_q;
	logic [WORD_W-1:0] out_front_q;
	logic [WORD_W-1:0] out_rear_q;
	logic              out_empty_q;
	logic              out_full_q;

	logic              in_fire;
	logic              cfg_write;
	mode_t             op_mode;
	logic              is_insert;
	logic [CMP_W-1:0]  eff_cap;
	logic              full_now;
	logic              success;
	logic              load_out;
	cell_ctl_t         ctl;

	logic [WORD_W-1:0] cell_value [DEPTH];
	logic              cell_valid [DEPTH];
	logic [WORD_W-1:0] rear_chain [DEPTH+1];

	// Configuration write and readback.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_CAPACITY);

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_CAPACITY) begin
			prdata = PDATA_W'(capacity_q);
		end
	end

	// Effective capacity saturates at the number of cells.
	always_comb begin
		eff_cap = CMP_W'(capacity_q);
		if (CMP_W'(capacity_q) > CMP_W'(DEPTH)) begin
			eff_cap = CMP_W'(DEPTH);
		end
	end

	assign full_now = CMP_W'(count_q) >= eff_cap;

	// Decode the incoming operation and decide whether it is carried out.
	assign op_mode   = mode_t'(mode);
	assign is_insert = (op_mode == MODE_INS_FRONT) || (op_mode == MODE_INS_REAR);
	assign success   = is_insert ? !full_now : (count_q != '0);
	assign in_ready  = !busy_q;
	assign in_fire   = in_valid && in_ready;

	// Broadcast control for the cell row.
	assign ctl.go   = in_fire && success;
	assign ctl.mode = op_mode;
	assign ctl.data = value;

	// Cell chain.
	assign rear_chain[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] lval;
		logic              lvld;
		logic [WORD_W-1:0] rval;
		logic              rvld;

		if (i == 0) begin : g_first
			assign lval = value;
			assign lvld = 1'b1;
		end else begin : g_inner_l
			assign lval = cell_value[i-1];
			assign lvld = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rval = '0;
			assign rvld = 1'b0;
		end else begin : g_inner_r
			assign rval = cell_value[i+1];
			assign rvld = cell_valid[i+1];
		end

		bcd_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.left_value  (lval),
			.left_valid  (lvld),
			.right_value (rval),
			.right_valid (rvld),
			.rear_in     (rear_chain[i+1]),
			.cell_value  (cell_value[i]),
			.cell_valid  (cell_valid[i]),
			.rear_out    (rear_chain[i])
		);
	end

	// The result is captured once the cells hold the updated row and the output is free.
	assign load_out = busy_q && (!out_valid_q || out_ready);

	// Control state: capacity, entry count, operation tracking and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			count_q     <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				capacity_q <= pwdata[CAP_W-1:0];
			end
			if (in_fire) begin
				busy_q <= 1'b1;
				if (success) begin
					count_q <= is_insert ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
				end
			end else if (load_out) begin
				busy_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ok_q <= success;
		end
		if (load_out) begin
			out_ok_q    <= ok_q;
			out_empty_q <= (count_q == '0);
			out_full_q  <= full_now;
			out_front_q <= cell_valid[0] ? cell_value[0] : EMPTY_WORD;
			out_rear_q  <= cell_valid[0] ? rear_chain[0] : EMPTY_WORD;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = out_ok_q;
	assign front_value = out_front_q;
	assign rear_value  = out_rear_q;
	assign is_empty    = out_empty_q;
	assign is_full     = out_full_q;

endmodule
`default_nettype wire
